>>> rtl/bpfa_pkg.sv
// Shared constants, codes and control/status types of the page frame allocator.
package bpfa_pkg;

  localparam int TOTAL_FRAMES = 8192;
  localparam int PAGE_SHIFT   = 12;
  localparam int MAP_WORDS    = (TOTAL_FRAMES + 31) / 32;
  localparam int WIDX_W       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int FR_W         = WIDX_W + 5;
  localparam int CNT_W        = $clog2(TOTAL_FRAMES + 1);

  localparam int CMD_W   = 2;
  localparam int STAT_W  = 2;
  localparam int FADDR_W = 25;
  localparam int FREE_W  = 14;
  localparam int RES_W   = 14;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [31:0]      FULL_WORD      = 32'hFFFF_FFFF;
  localparam logic [RES_W-1:0] RESERVED_RESET = 14'd1280;

  // Register index within the APB map (byte address 4*index).
  localparam logic REG_RESERVED_FRAMES = 1'b0;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_INIT  = 2'd2
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_NOMEM   = 2'd1,
    ST_BADFREE = 2'd2
  } status_e;

  // Controller to datapath.
  typedef struct packed {
    logic load;       // capture the accepted item
    logic quick;      // finish without touching the bitmap
    logic init_wr;    // write one init word, advance
    logic scan_rd;    // read bitmap word for the allocate scan
    logic alloc_chk;  // test the word read, claim a frame or advance
    logic free_rd;    // read bitmap word holding the frame to free
    logic free_chk;   // clear the frame bit if it is in use
    logic push;       // move the pending result into the output register
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    cmd_e cmd;
    logic full;
    logic range_bad;
    logic last_word;
    logic hit;
    logic out_free;
  } dp_sts_t;

endpackage

>>> rtl/bitmap_page_frame_allocator.sv
// Top level of the first-fit page frame allocator: APB register, sequencer and datapath.
//
// Usage:
//   Command channel (in_valid_i / in_stall_o, command_i, block_address_i): one item per
//   command. Allocate returns the byte address of the lowest free frame, free releases
//   the frame containing block_address_i, init rebuilds the bitmap with the frames below
//   reserved_frames marked used. Result channel (out_valid_o / out_stall_i, status_o,
//   frame_address_o, free_frames_o): exactly one item per command, in order.
//   APB register 0 (byte address 0) holds reserved_frames; write it only while idle.
// Sequence, from accept to result valid:
//   free reads the frame's bitmap word, then clears the bit; out-of-range free, allocate
//   with no free frame or unknown code finish without touching the bitmap; allocate reads
//   and checks one bitmap word after another, starting at the lowest word that may hold a
//   free frame; init writes one bitmap word per cycle (256 at 8192 frames). The bitmap
//   memory has one write and one registered read port, so an allocate scan reads each word
//   before it checks it. A busy output register holds the result while it is stalled. One
//   item is in work at a time; the next is taken in the cycle after the result loads.
// Reset: every frame reads as used (per-word valid bits clear), used count is the total,
//   reserved_frames returns to 1280. No clearing pass is needed.
// Stall: a result waits in the output register while out_stall_i is high; the block
//   still accepts the next item and holds that item's result until the register frees.
module bitmap_page_frame_allocator import bpfa_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // command channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [CMD_W-1:0]    command_i,
  input  logic [31:0]         block_address_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STAT_W-1:0]   status_o,
  output logic [FADDR_W-1:0]  frame_address_o,
  output logic [FREE_W-1:0]   free_frames_o,
  // APB register port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  logic [RES_W-1:0] reserved_q;
  logic             reg_idx;
  ctrl_cmd_t        cmd;
  dp_sts_t          sts;

  // Registers sit on word addresses; bit 2 picks the register.
  assign reg_idx = paddr[2];
  assign pready  = 1'b1;
  assign prdata  = (reg_idx == REG_RESERVED_FRAMES) ? PDATA_W'(reserved_q) : '0;

  // Write on the access phase; writes to an unmapped address are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reserved_q <= RESERVED_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (reg_idx == REG_RESERVED_FRAMES) && (paddr[1:0] == 2'b00)) begin
      reserved_q <= pwdata[RES_W-1:0];
    end
  end

  bpfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bpfa_dpath u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .command_i         (command_i),
    .block_address_i   (block_address_i),
    .reserved_frames_i (reserved_q),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .status_o          (status_o),
    .frame_address_o   (frame_address_o),
    .free_frames_o     (free_frames_o)
  );

endmodule

>>> rtl/bpfa_ctrl.sv
// Sequencer of the page frame allocator: decodes an item and steps the datapath.
module bpfa_ctrl import bpfa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  dp_sts_t   sts_i,
  output ctrl_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_INIT,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_FREE_RD,
    S_FREE_CHK,
    S_DONE
  } state_e;

  state_e state_q;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_IDLE:     cmd_o.load = in_valid_i;
      S_DECODE: begin
        case (sts_i.cmd)
          CMD_ALLOC: cmd_o.quick = sts_i.full;
          CMD_FREE:  cmd_o.quick = sts_i.range_bad;
          CMD_INIT:  cmd_o.quick = 1'b0;
          default:   cmd_o.quick = 1'b1;
        endcase
      end
      S_INIT:     cmd_o.init_wr   = 1'b1;
      S_SCAN_RD:  cmd_o.scan_rd   = 1'b1;
      S_SCAN_CHK: cmd_o.alloc_chk = 1'b1;
      S_FREE_RD:  cmd_o.free_rd   = 1'b1;
      S_FREE_CHK: cmd_o.free_chk  = 1'b1;
      S_DONE:     cmd_o.push      = sts_i.out_free;
      default:    cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_DECODE;
        end
        S_DECODE: begin
          case (sts_i.cmd)
            CMD_ALLOC: state_q <= sts_i.full ? S_DONE : S_SCAN_RD;
            CMD_FREE:  state_q <= sts_i.range_bad ? S_DONE : S_FREE_RD;
            CMD_INIT:  state_q <= S_INIT;
            default:   state_q <= S_DONE;
          endcase
        end
        S_INIT: begin
          if (sts_i.last_word) state_q <= S_DONE;
        end
        S_SCAN_RD:  state_q <= S_SCAN_CHK;
        S_SCAN_CHK: begin
          if (sts_i.hit || sts_i.last_word) state_q <= S_DONE;
          else                              state_q <= S_SCAN_RD;
        end
        S_FREE_RD:  state_q <= S_FREE_CHK;
        S_FREE_CHK: state_q <= S_DONE;
        S_DONE: begin
          if (sts_i.out_free) state_q <= S_IDLE;
        end
        default:    state_q <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/bpfa_dpath.sv
// Datapath of the page frame allocator: bitmap memory, counters, scan pointer, result register.
module bpfa_dpath import bpfa_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctrl_cmd_t           cmd_i,
  output dp_sts_t             sts_o,
  input  logic [CMD_W-1:0]    command_i,
  input  logic [31:0]         block_address_i,
  input  logic [RES_W-1:0]    reserved_frames_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic [STAT_W-1:0]   status_o,
  output logic [FADDR_W-1:0]  frame_address_o,
  output logic [FREE_W-1:0]   free_frames_o
);

  // Bitmap store; an entry never written reads as all used.
  logic [31:0]          mem_q [MAP_WORDS];
  logic [MAP_WORDS-1:0] vld_q;

  cmd_e              cmd_q;
  logic              range_bad_q;
  logic [WIDX_W-1:0] ptr_q;
  logic [4:0]        bit_q;
  logic [WIDX_W-1:0] low_q;
  logic [CNT_W-1:0]  used_q;
  logic [31:0]       rd_word_q;
  logic              rd_valid_q;
  status_e           pend_status_q;
  logic [FR_W-1:0]   pend_frame_q;

  logic                out_valid_q;
  status_e             status_q;
  logic [FADDR_W-1:0]  faddr_q;
  logic [FREE_W-1:0]   free_q;

  logic [31:0]       fnum;
  logic [31:0]       res_sat;
  logic [31:0]       res_word;
  logic [WIDX_W-1:0] res_low;
  logic [31:0]       word_eff;
  logic [31:0]       init_word;
  logic [4:0]        zero_idx;
  logic              hit;
  logic              last_word;
  logic              full;
  logic              free_ok;
  logic              we;
  logic [31:0]       wdata;
  logic              out_free;
  logic [63:0]       faddr_wide;

  assign fnum      = block_address_i >> PAGE_SHIFT;
  assign res_sat   = (32'(reserved_frames_i) > 32'(TOTAL_FRAMES)) ?
                     32'(TOTAL_FRAMES) : 32'(reserved_frames_i);
  assign res_word  = res_sat >> 5;
  assign res_low   = (res_word >= 32'(MAP_WORDS)) ? WIDX_W'(MAP_WORDS - 1) :
                     res_word[WIDX_W-1:0];
  assign word_eff  = rd_valid_q ? rd_word_q : FULL_WORD;
  assign hit       = (word_eff != FULL_WORD);
  assign last_word = (ptr_q == WIDX_W'(MAP_WORDS - 1));
  assign full      = (used_q == CNT_W'(TOTAL_FRAMES));
  assign free_ok   = word_eff[bit_q] && (used_q != '0);
  assign out_free  = !out_valid_q || !out_stall_i;

  // Frames below the reserved boundary and slack frames past the end stay used.
  always_comb begin
    logic [31:0] fr;
    for (int j = 0; j < 32; j++) begin
      fr = 32'({ptr_q, 5'(j)});
      init_word[j] = (fr < res_sat) || (fr >= 32'(TOTAL_FRAMES));
    end
  end

  // Lowest clear bit of the word read.
  always_comb begin
    zero_idx = '0;
    for (int i = 31; i >= 0; i--) begin
      if (!word_eff[i]) zero_idx = 5'(i);
    end
  end

  always_comb begin
    we    = 1'b0;
    wdata = init_word;
    if (cmd_i.init_wr) begin
      we    = 1'b1;
      wdata = init_word;
    end else if (cmd_i.alloc_chk) begin
      we    = hit;
      wdata = word_eff | (32'd1 << zero_idx);
    end else if (cmd_i.free_chk) begin
      we    = free_ok;
      wdata = word_eff & ~(32'd1 << bit_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[ptr_q] <= wdata;
    if (cmd_i.scan_rd || cmd_i.free_rd) rd_word_q <= mem_q[ptr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (we) vld_q[ptr_q] <= 1'b1;
      if (cmd_i.scan_rd || cmd_i.free_rd) rd_valid_q <= vld_q[ptr_q];
    end
  end

  // Item capture, pointer, hint and used count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q         <= CMD_ALLOC;
      range_bad_q   <= 1'b0;
      ptr_q         <= '0;
      bit_q         <= '0;
      low_q         <= '0;
      used_q        <= CNT_W'(TOTAL_FRAMES);
      pend_status_q <= ST_OK;
      pend_frame_q  <= '0;
    end else begin
      if (cmd_i.load) begin
        cmd_q       <= cmd_e'(command_i);
        range_bad_q <= (fnum >= 32'(TOTAL_FRAMES));
        bit_q       <= fnum[4:0];
        case (cmd_e'(command_i))
          CMD_INIT:  ptr_q <= '0;
          CMD_FREE:  ptr_q <= fnum[5 +: WIDX_W];
          CMD_ALLOC: ptr_q <= low_q;
          default:   ptr_q <= low_q;
        endcase
      end

      if (cmd_i.quick) begin
        pend_frame_q <= '0;
        case (cmd_q)
          CMD_ALLOC: pend_status_q <= ST_NOMEM;
          CMD_FREE:  pend_status_q <= ST_BADFREE;
          default:   pend_status_q <= ST_OK;
        endcase
      end

      if (cmd_i.init_wr) begin
        ptr_q <= ptr_q + WIDX_W'(1);
        if (last_word) begin
          used_q        <= CNT_W'(res_sat);
          low_q         <= res_low;
          pend_status_q <= ST_OK;
          pend_frame_q  <= '0;
        end
      end

      if (cmd_i.alloc_chk) begin
        if (hit) begin
          used_q        <= used_q + CNT_W'(1);
          low_q         <= ptr_q;
          pend_status_q <= ST_OK;
          pend_frame_q  <= {ptr_q, zero_idx};
        end else begin
          ptr_q <= ptr_q + WIDX_W'(1);
          // Scan ran off the end: report no memory.
          if (last_word) begin
            pend_status_q <= ST_NOMEM;
            pend_frame_q  <= '0;
          end
        end
      end

      if (cmd_i.free_chk) begin
        pend_frame_q <= '0;
        if (free_ok) begin
          used_q        <= used_q - CNT_W'(1);
          pend_status_q <= ST_OK;
          if (ptr_q < low_q) low_q <= ptr_q;
        end else begin
          pend_status_q <= ST_BADFREE;
        end
      end
    end
  end

  assign faddr_wide = 64'(pend_frame_q) << PAGE_SHIFT;

  // Output register: hold while stalled, load on push.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      status_q <= pend_status_q;
      faddr_q  <= faddr_wide[FADDR_W-1:0];
      free_q   <= FREE_W'(CNT_W'(TOTAL_FRAMES) - used_q);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign frame_address_o = faddr_q;
  assign free_frames_o   = free_q;

  assign sts_o.cmd       = cmd_q;
  assign sts_o.full      = full;
  assign sts_o.range_bad = range_bad_q;
  assign sts_o.last_word = last_word;
  assign sts_o.hit       = hit;
  assign sts_o.out_free  = out_free;

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CNT_W'(TOTAL_FRAMES))
    else $error("used count above total frames");

  a_alloc_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.alloc_chk && hit) |=> (used_q == $past(used_q) + CNT_W'(1)))
    else $error("allocate did not raise used count");

  a_free_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.free_chk && free_ok) |=> (used_q == $past(used_q) - CNT_W'(1)))
    else $error("free did not lower used count");

  a_scan_hint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_rd |-> (ptr_q >= low_q))
    else $error("scan below the lowest possibly free word");

  a_push_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> out_free)
    else $error("result pushed over an untaken result");

endmodule
